// File: rtl/fcgi_pkg.sv
// Shared types and constants for the FastCGI record deframer.
`default_nettype none
package fcgi_pkg;

   localparam int unsigned ReqIdWidth  = 16;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic [ReqIdWidth-1:0] ReqIdReset = 16'd1;

   // register index within the CSR space
   localparam logic CSR_IDX_REQUEST_ID = 1'b0;

   // header byte positions
   localparam logic [2:0] HDR_VERSION = 3'd0;
   localparam logic [2:0] HDR_TYPE    = 3'd1;
   localparam logic [2:0] HDR_ID_HI   = 3'd2;
   localparam logic [2:0] HDR_ID_LO   = 3'd3;
   localparam logic [2:0] HDR_LEN_HI  = 3'd4;
   localparam logic [2:0] HDR_LEN_LO  = 3'd5;
   localparam logic [2:0] HDR_PAD     = 3'd6;
   localparam logic [2:0] HDR_RSVD    = 3'd7;

   localparam logic [7:0]  FCGI_VERSION     = 8'd1;
   localparam logic [7:0]  FCGI_TYPE_END    = 8'd3;
   localparam logic [7:0]  FCGI_TYPE_STDOUT = 8'd6;
   localparam logic [7:0]  FCGI_TYPE_STDERR = 8'd7;
   localparam logic [15:0] END_BODY_LEN     = 16'd8;
   localparam logic [15:0] END_STATUS_POS   = 16'd4;

   // protocol status byte of an end-request body
   localparam logic [7:0] PS_COMPLETE     = 8'd0;
   localparam logic [7:0] PS_CANT_MPX     = 8'd1;
   localparam logic [7:0] PS_OVERLOADED   = 8'd2;
   localparam logic [7:0] PS_UNKNOWN_ROLE = 8'd3;

   localparam logic [1:0] EV_PAYLOAD  = 2'd0;
   localparam logic [1:0] EV_RECORD   = 2'd1;
   localparam logic [1:0] EV_COMPLETE = 2'd2;
   localparam logic [1:0] EV_ERROR    = 2'd3;

   localparam logic [2:0] ERR_VERSION     = 3'd0;
   localparam logic [2:0] ERR_ID          = 3'd1;
   localparam logic [2:0] ERR_TYPE        = 3'd2;
   localparam logic [2:0] ERR_END_LEN     = 3'd3;
   localparam logic [2:0] ERR_CANT_MPX    = 3'd4;
   localparam logic [2:0] ERR_OVERLOADED  = 3'd5;
   localparam logic [2:0] ERR_UNKNOWN_ROLE = 3'd6;
   localparam logic [2:0] ERR_UNKNOWN_STATUS = 3'd7;

   localparam logic [1:0] TAG_NONE = 2'd0;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_CONTENT = 3'd1,
      PH_PADDING = 3'd2,
      PH_ERROR   = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      RK_END     = 2'd0,
      RK_STDOUT  = 2'd1,
      RK_STDERR  = 2'd2,
      RK_INVALID = 2'd3
   } rec_kind_type;

   typedef struct packed {
      logic      out_free;
      phase_type phase;
   } parse_status_type;

endpackage
`default_nettype wire

// File: rtl/fcgi_csr.sv
// APB register block holding the expected request id.
`default_nettype none
module fcgi_csr #(
   parameter logic [fcgi_pkg::ReqIdWidth-1:0] RESET_ID = fcgi_pkg::ReqIdReset
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [fcgi_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [fcgi_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic      [fcgi_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                   csr_pready,
   output logic      [fcgi_pkg::ReqIdWidth-1:0]   expected_request_id
);
   import fcgi_pkg::*;

   logic [ReqIdWidth-1:0] req_id_ff;
   logic [ReqIdWidth-1:0] req_id_in;
   logic                  reg_index;

   assign reg_index = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign expected_request_id = req_id_ff;

   always_comb begin
      req_id_in = req_id_ff;
      if (csr_psel && csr_penable && csr_pwrite && (reg_index == CSR_IDX_REQUEST_ID)) begin
         req_id_in = csr_pwdata[ReqIdWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_id_ff <= RESET_ID;
      end else begin
         req_id_ff <= req_id_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == CSR_IDX_REQUEST_ID) begin
         csr_prdata = {{(CsrDataWidth-ReqIdWidth){1'b0}}, req_id_ff};
      end
   end

endmodule
`default_nettype wire

// File: rtl/fcgi_parse.sv
// Record parser: per-byte state update and the result register.
`default_nettype none
module fcgi_parse (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step,
   input  wire logic [7:0]                      stream_byte,
   input  wire logic [fcgi_pkg::ReqIdWidth-1:0] expected_request_id,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic      [1:0]                      rsp_event_kind,
   output logic      [1:0]                      rsp_stream_tag,
   output logic      [7:0]                      rsp_payload_byte,
   output logic                                 rsp_record_last,
   output logic      [31:0]                     rsp_application_status,
   output logic      [2:0]                      rsp_error_code,
   output fcgi_pkg::parse_status_type           status
);
   import fcgi_pkg::*;

   phase_type    phase_ff, phase_in;
   logic [2:0]   byte_index_ff, byte_index_in;
   rec_kind_type kind_ff, kind_in;
   logic [7:0]   shift_ff, shift_in;
   logic [15:0]  content_ff, content_in;
   logic [7:0]   padding_ff, padding_in;
   logic [31:0]  app_status_ff, app_status_in;

   logic         res_valid;
   logic [1:0]   res_kind;
   logic [1:0]   res_tag;
   logic [7:0]   res_byte;
   logic         res_last;
   logic [31:0]  res_app;
   logic [2:0]   res_err;

   logic         valid_ff, valid_in;
   logic [1:0]   kind_out_ff;
   logic [1:0]   tag_ff;
   logic [7:0]   byte_ff;
   logic         last_ff;
   logic [31:0]  app_ff;
   logic [2:0]   err_ff;

   logic [15:0]  body_pos;
   logic         out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign body_pos = END_BODY_LEN - content_ff;

   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      kind_in       = kind_ff;
      shift_in      = shift_ff;
      content_in    = content_ff;
      padding_in    = padding_ff;
      app_status_in = app_status_ff;
      res_valid = 1'b0;
      res_kind  = EV_PAYLOAD;
      res_tag   = TAG_NONE;
      res_byte  = '0;
      res_last  = 1'b0;
      res_app   = '0;
      res_err   = ERR_VERSION;

      if (step) begin
         unique case (phase_ff)
            PH_HEADER: begin
               byte_index_in = byte_index_ff + 3'd1;
               unique case (byte_index_ff)
                  HDR_VERSION: begin
                     if (stream_byte != FCGI_VERSION) begin
                        phase_in = PH_ERROR;
                        res_valid = 1'b1;
                        res_kind = EV_ERROR;
                        res_err = ERR_VERSION;
                     end
                  end
                  HDR_TYPE: begin
                     priority if (stream_byte == FCGI_TYPE_STDOUT) kind_in = RK_STDOUT;
                     else if (stream_byte == FCGI_TYPE_STDERR) kind_in = RK_STDERR;
                     else if (stream_byte == FCGI_TYPE_END) kind_in = RK_END;
                     else kind_in = RK_INVALID;
                  end
                  HDR_ID_HI, HDR_LEN_HI: begin
                     shift_in = stream_byte;
                  end
                  HDR_ID_LO: begin
                     // id is checked before the type
                     if ({shift_ff, stream_byte} != expected_request_id) begin
                        phase_in = PH_ERROR;
                        res_valid = 1'b1;
                        res_kind = EV_ERROR;
                        res_err = ERR_ID;
                     end else if (kind_ff == RK_INVALID) begin
                        phase_in = PH_ERROR;
                        res_valid = 1'b1;
                        res_kind = EV_ERROR;
                        res_err = ERR_TYPE;
                     end
                  end
                  HDR_LEN_LO: begin
                     content_in = {shift_ff, stream_byte};
                     if (kind_ff == RK_END && {shift_ff, stream_byte} != END_BODY_LEN) begin
                        phase_in = PH_ERROR;
                        res_valid = 1'b1;
                        res_kind = EV_ERROR;
                        res_err = ERR_END_LEN;
                     end
                  end
                  HDR_PAD: begin
                     padding_in = stream_byte;
                  end
                  HDR_RSVD: begin
                     byte_index_in = '0;
                     priority if (content_ff != '0) begin
                        phase_in = PH_CONTENT;
                     end else if (padding_ff != '0) begin
                        phase_in = PH_PADDING;
                     end else begin
                        phase_in = PH_HEADER;
                        res_valid = 1'b1;
                        if (kind_ff == RK_END) begin
                           res_kind = EV_COMPLETE;
                           res_app = app_status_ff;
                        end else begin
                           res_kind = EV_RECORD;
                           res_tag = kind_ff;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            PH_CONTENT: begin
               content_in = content_ff - 16'd1;
               if (kind_ff == RK_END) begin
                  if (body_pos < END_STATUS_POS) begin
                     app_status_in = {app_status_ff[23:0], stream_byte};
                  end
                  if (body_pos == END_STATUS_POS && stream_byte != PS_COMPLETE) begin
                     phase_in = PH_ERROR;
                     res_valid = 1'b1;
                     res_kind = EV_ERROR;
                     priority if (stream_byte == PS_CANT_MPX) res_err = ERR_CANT_MPX;
                     else if (stream_byte == PS_OVERLOADED) res_err = ERR_OVERLOADED;
                     else if (stream_byte == PS_UNKNOWN_ROLE) res_err = ERR_UNKNOWN_ROLE;
                     else res_err = ERR_UNKNOWN_STATUS;
                  end else if (content_in == '0) begin
                     if (padding_ff != '0) begin
                        phase_in = PH_PADDING;
                     end else begin
                        phase_in = PH_HEADER;
                        byte_index_in = '0;
                        res_valid = 1'b1;
                        res_kind = EV_COMPLETE;
                        // the last body byte lies past the status bytes, so app_status_in equals the stored status
                        res_app = app_status_in;
                     end
                  end
               end else begin
                  res_valid = 1'b1;
                  res_kind = EV_PAYLOAD;
                  res_tag = kind_ff;
                  res_byte = stream_byte;
                  if (content_in == '0) begin
                     if (padding_ff != '0) begin
                        phase_in = PH_PADDING;
                     end else begin
                        phase_in = PH_HEADER;
                        byte_index_in = '0;
                        res_last = 1'b1;
                     end
                  end
               end
            end
            PH_PADDING: begin
               padding_in = padding_ff - 8'd1;
               if (padding_in == '0) begin
                  phase_in = PH_HEADER;
                  byte_index_in = '0;
                  res_valid = 1'b1;
                  if (kind_ff == RK_END) begin
                     res_kind = EV_COMPLETE;
                     res_app = app_status_ff;
                  end else begin
                     res_kind = EV_RECORD;
                     res_tag = kind_ff;
                  end
               end
            end
            PH_ERROR: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (step && res_valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         byte_index_ff <= '0;
         kind_ff       <= RK_END;
         shift_ff      <= '0;
         content_ff    <= '0;
         padding_ff    <= '0;
         app_status_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         kind_ff       <= kind_in;
         shift_ff      <= shift_in;
         content_ff    <= content_in;
         padding_ff    <= padding_in;
         app_status_ff <= app_status_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         kind_out_ff <= res_kind;
         tag_ff      <= res_tag;
         byte_ff     <= res_byte;
         last_ff     <= res_last;
         app_ff      <= res_app;
         err_ff      <= (res_kind == EV_ERROR) ? res_err : ERR_VERSION;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_event_kind         = kind_out_ff;
   assign rsp_stream_tag         = tag_ff;
   assign rsp_payload_byte       = byte_ff;
   assign rsp_record_last        = last_ff;
   assign rsp_application_status = app_ff;
   assign rsp_error_code         = err_ff;

   assign status.out_free = out_free;
   assign status.phase    = phase_ff;

endmodule
`default_nettype wire

// File: rtl/fastcgi_record_deframer.sv
// Top level of the FastCGI response record deframer.
//
//   channel  ports   direction  payload
//   req      req_*   in         stream_byte
//   rsp      rsp_*   out        event_kind, stream_tag, payload_byte, record_last,
//                               application_status, error_code
//   csr      csr_*   in/out     APB, expected_request_id at offset 0
//
// One byte per cycle while rsp is not stalled: a byte is captured in the input
// register, then parsed into the result register, which drives rsp_valid; the
// result is taken on an edge where rsp_ready is high.
// Throughput is set by the result register: the input register drains only
// while the result register is empty or being taken, so rsp_ready low stalls req.
// Reset is synchronous and returns the parser to header collection with id RESET_ID (1 by default).
`default_nettype none
module fastcgi_record_deframer #(
   parameter logic [fcgi_pkg::ReqIdWidth-1:0] RESET_ID = fcgi_pkg::ReqIdReset
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_stream_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [1:0]                        rsp_event_kind,
   output logic      [1:0]                        rsp_stream_tag,
   output logic      [7:0]                        rsp_payload_byte,
   output logic                                   rsp_record_last,
   output logic      [31:0]                       rsp_application_status,
   output logic      [2:0]                        rsp_error_code,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [fcgi_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [fcgi_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic      [fcgi_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import fcgi_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  step;
   logic [ReqIdWidth-1:0] expected_request_id;
   parse_status_type      status;

   assign step      = in_valid_ff && status.out_free;
   assign req_ready = !in_valid_ff || status.out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (step) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   fcgi_csr #(
      .RESET_ID(RESET_ID)
   ) u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .expected_request_id(expected_request_id)
   );

   fcgi_parse u_parse (
      .clock                 (clock),
      .reset                 (reset),
      .step                  (step),
      .stream_byte           (in_byte_ff),
      .expected_request_id   (expected_request_id),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_stream_tag        (rsp_stream_tag),
      .rsp_payload_byte      (rsp_payload_byte),
      .rsp_record_last       (rsp_record_last),
      .rsp_application_status(rsp_application_status),
      .rsp_error_code        (rsp_error_code),
      .status                (status)
   );

   // error phase is sticky until reset
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (status.phase == PH_ERROR) |=> (status.phase == PH_ERROR))
      else $error("parser left the error phase");

   // a buffered byte is never dropped while the result side is stalled
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !status.out_free) |=> in_valid_ff)
      else $error("input byte lost during stall");

   // record_last only marks payload bytes
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_last) |-> (rsp_event_kind == EV_PAYLOAD))
      else $error("record_last on a non-payload result");

   // an error result carries no stream tag and no status
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind == EV_ERROR) |->
         (rsp_stream_tag == TAG_NONE && rsp_application_status == '0))
      else $error("error result carries stray fields");

endmodule
`default_nettype wire
